// File: src/dalt_pkg.sv
// Shared types, constants and the microcode program of the light tracker.
`default_nettype none

package dalt_pkg;

   // Default build values of the top-level parameters.
   localparam int SAMPLE_BITS_DEF = 12;
   localparam int PARK_PAN_DEF    = 90;
   localparam int PARK_TILT_DEF   = 45;

   // Fixed field widths.
   localparam int TOL_BITS       = 12;
   localparam int GAIN_BITS      = 16;
   localparam int STEP_BITS      = 16;
   localparam int LIMIT_BITS     = 8;
   localparam int ANGLE_BITS     = 16;
   localparam int FRAC_BITS      = 8;
   localparam int POS_BITS       = 8;
   localparam int RSP_DATA_BITS  = 2 * POS_BITS;
   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = 16;

   // Quotient bits kept by the divider; a larger quotient always saturates.
   localparam int QUO_BITS  = STEP_BITS + 1;
   localparam int LOOP_BITS = $clog2(QUO_BITS);
   localparam int PC_BITS   = 4;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TOLERANCE  = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PAN_GAIN   = 8'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TILT_GAIN  = 8'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_STEP   = 8'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PAN_LOWER  = 8'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PAN_UPPER  = 8'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TILT_LOWER = 8'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TILT_UPPER = 8'd7;

   // Register values after reset.
   localparam logic [TOL_BITS-1:0]   TOL_RESET        = 12'd50;
   localparam logic [GAIN_BITS-1:0]  GAIN_RESET       = 16'd655;
   localparam logic [STEP_BITS-1:0]  MAX_STEP_RESET   = 16'd512;
   localparam logic [LIMIT_BITS-1:0] LOWER_RESET      = 8'd0;
   localparam logic [LIMIT_BITS-1:0] UPPER_RESET      = 8'd180;

   // Datapath operations selected by a control word.
   typedef enum logic [3:0] {
      OP_WAIT,
      OP_DIFF,
      OP_MUL1,
      OP_MUL2,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_CLAMP,
      OP_UPDATE,
      OP_EMIT
   } op_type;

   // Sequencer branch conditions.
   typedef enum logic [1:0] {
      JMP_NONE,
      JMP_ALWAYS,
      JMP_LOOP
   } cond_type;

   typedef enum logic {
      AXIS_PAN,
      AXIS_TILT
   } axis_type;

   typedef struct packed {
      op_type               op;
      axis_type             axis;
      cond_type             cond;
      logic [PC_BITS-1:0]   target;
   } ctrl_type;

   // Handshake status that can hold the sequencer on its current step.
   typedef struct packed {
      logic req_valid;
      logic out_busy;
   } seq_hold_type;

   // Microcode program: one control word per step.
   function automatic ctrl_type ucode(input logic [PC_BITS-1:0] pc);
      ctrl_type cw;
      cw = '{OP_WAIT, AXIS_PAN, JMP_NONE, '0};
      unique case (pc)
         4'd0:  cw = '{OP_WAIT,     AXIS_PAN,  JMP_NONE,   4'd0};
         4'd1:  cw = '{OP_DIFF,     AXIS_PAN,  JMP_NONE,   4'd0};
         4'd2:  cw = '{OP_MUL1,     AXIS_PAN,  JMP_NONE,   4'd0};
         4'd3:  cw = '{OP_MUL2,     AXIS_PAN,  JMP_NONE,   4'd0};
         4'd4:  cw = '{OP_DIV_INIT, AXIS_PAN,  JMP_NONE,   4'd0};
         4'd5:  cw = '{OP_DIV_STEP, AXIS_PAN,  JMP_LOOP,   4'd5};
         4'd6:  cw = '{OP_CLAMP,    AXIS_PAN,  JMP_NONE,   4'd0};
         4'd7:  cw = '{OP_UPDATE,   AXIS_PAN,  JMP_NONE,   4'd0};
         4'd8:  cw = '{OP_DIFF,     AXIS_TILT, JMP_NONE,   4'd0};
         4'd9:  cw = '{OP_MUL1,     AXIS_TILT, JMP_NONE,   4'd0};
         4'd10: cw = '{OP_MUL2,     AXIS_TILT, JMP_NONE,   4'd0};
         4'd11: cw = '{OP_DIV_INIT, AXIS_TILT, JMP_NONE,   4'd0};
         4'd12: cw = '{OP_DIV_STEP, AXIS_TILT, JMP_LOOP,   4'd12};
         4'd13: cw = '{OP_CLAMP,    AXIS_TILT, JMP_NONE,   4'd0};
         4'd14: cw = '{OP_UPDATE,   AXIS_TILT, JMP_NONE,   4'd0};
         4'd15: cw = '{OP_EMIT,     AXIS_PAN,  JMP_ALWAYS, 4'd0};
         default: cw = '{OP_WAIT,   AXIS_PAN,  JMP_NONE,   4'd0};
      endcase
      return cw;
   endfunction

endpackage

`default_nettype wire

// File: src/dual_axis_light_tracker_step.sv
// Top level of the two-axis light tracker: stream ports, sequencer and datapath.
`default_nettype none

// Each accepted word holds four light samples. The block forms the halved
// pair sums, takes the horizontal and vertical differences and, per axis,
// computes difference * gain * min(|difference|, tolerance) / (tolerance * 256)
// with one shared multiplier and a one-bit-per-cycle restoring divider, clamps
// the step to the step limit, adds it to the stored Q8.8 angle and limits that
// angle. A microcoded sequencer runs the steps; of each axis's steps, the
// divider iterations, one per kept quotient bit, take the largest share. The
// next word is taken once the sequencer is back at its wait step, while an
// earlier result may still sit in the output register.
// Configuration writes are always ready and should only be issued while idle.
module dual_axis_light_tracker_step
   import dalt_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int PARK_PAN    = PARK_PAN_DEF,
   parameter int PARK_TILT   = PARK_TILT_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // light_top_left, light_top_right, light_bottom_left, light_bottom_right
   input  wire logic [((4*SAMPLE_BITS+7)/8)*8-1:0]   req_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // pan_position, tilt_position
   output logic [RSP_DATA_BITS-1:0]                  rsp_tdata,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0]            csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]             csr_data
);

   localparam int SB = SAMPLE_BITS;

   ctrl_type            ctrl;
   seq_hold_type        hold;
   logic                req_accept;
   logic                rsp_valid;
   logic [POS_BITS-1:0] pan_position, tilt_position;

   // Input words are taken only at the wait step.
   assign req_tready = (ctrl.op == OP_WAIT);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign hold.req_valid = req_tvalid;
   assign hold.out_busy  = rsp_valid && !rsp_tready;

   assign rsp_tvalid = rsp_valid;
   assign rsp_tdata  = {tilt_position, pan_position};

   dalt_seq u_seq (
      .clock (clock),
      .reset (reset),
      .hold  (hold),
      .ctrl  (ctrl)
   );

   dalt_dp #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .PARK_PAN    (PARK_PAN),
      .PARK_TILT   (PARK_TILT)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .ctrl               (ctrl),
      .req_accept         (req_accept),
      .light_top_left     (req_tdata[SB-1:0]),
      .light_top_right    (req_tdata[2*SB-1:SB]),
      .light_bottom_left  (req_tdata[3*SB-1:2*SB]),
      .light_bottom_right (req_tdata[4*SB-1:3*SB]),
      .csr_write          (csr_valid),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_ready          (rsp_tready),
      .rsp_valid          (rsp_valid),
      .pan_position       (pan_position),
      .tilt_position      (tilt_position)
   );

endmodule

`default_nettype wire

// File: src/dalt_seq.sv
// Microcode sequencer: program counter, loop counter and control word fetch.
`default_nettype none

module dalt_seq
   import dalt_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire seq_hold_type hold,
   output ctrl_type          ctrl
);

   logic [PC_BITS-1:0]   pc_ff, pc_in;
   logic [LOOP_BITS-1:0] loop_cnt_ff, loop_cnt_in;
   logic                 stay;

   // Fetch the control word of the current step.
   assign ctrl = ucode(pc_ff);

   // Hold while waiting for a word or while the result register is still full.
   assign stay = ((ctrl.op == OP_WAIT) && !hold.req_valid) ||
                 ((ctrl.op == OP_EMIT) && hold.out_busy);

   // Next step and loop count.
   always_comb begin
      pc_in       = pc_ff;
      loop_cnt_in = loop_cnt_ff;
      if (!stay) begin
         unique case (ctrl.cond)
            JMP_NONE:   pc_in = pc_ff + PC_BITS'(1);
            JMP_ALWAYS: pc_in = ctrl.target;
            JMP_LOOP: begin
               if (loop_cnt_ff != '0) begin
                  pc_in       = ctrl.target;
                  loop_cnt_in = loop_cnt_ff - LOOP_BITS'(1);
               end else begin
                  pc_in       = pc_ff + PC_BITS'(1);
                  loop_cnt_in = LOOP_BITS'(QUO_BITS - 1);
               end
            end
            default: pc_in = pc_ff + PC_BITS'(1);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff       <= '0;
         loop_cnt_ff <= LOOP_BITS'(QUO_BITS - 1);
      end else begin
         pc_ff       <= pc_in;
         loop_cnt_ff <= loop_cnt_in;
      end
   end

   // A divider loop step with iterations left repeats itself.
   assert property (@(posedge clock) disable iff (reset)
      (ctrl.cond == JMP_LOOP) && (loop_cnt_ff != '0) |=> pc_ff == $past(pc_ff))
      else $error("divider loop left early");

   // Outside the divider loop the counter sits at its reload value.
   assert property (@(posedge clock) disable iff (reset)
      (ctrl.op != OP_DIV_STEP) |-> loop_cnt_ff == LOOP_BITS'(QUO_BITS - 1))
      else $error("loop counter not reloaded");

   // After a result is written the program returns to the wait step.
   assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_EMIT) && !hold.out_busy |=> ctrl.op == OP_WAIT)
      else $error("program did not return to wait");

endmodule

`default_nettype wire

// File: src/dalt_dp.sv
// Tracker datapath: configuration registers, shared multiplier, divider and angles.
`default_nettype none

module dalt_dp
   import dalt_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int PARK_PAN    = PARK_PAN_DEF,
   parameter int PARK_TILT   = PARK_TILT_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire ctrl_type                  ctrl,
   input  wire logic                      req_accept,
   input  wire logic [SAMPLE_BITS-1:0]    light_top_left,
   input  wire logic [SAMPLE_BITS-1:0]    light_top_right,
   input  wire logic [SAMPLE_BITS-1:0]    light_bottom_left,
   input  wire logic [SAMPLE_BITS-1:0]    light_bottom_right,
   input  wire logic                      csr_write,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_data,
   input  wire logic                      rsp_ready,
   output logic                           rsp_valid,
   output logic [POS_BITS-1:0]            pan_position,
   output logic [POS_BITS-1:0]            tilt_position
);

   localparam int SB    = SAMPLE_BITS;
   localparam int MULAW = SB + GAIN_BITS;
   localparam int MULPW = MULAW + GAIN_BITS;
   localparam int PRODW = MULAW + TOL_BITS;
   localparam int HW    = PRODW - FRAC_BITS - QUO_BITS;
   localparam int CMPW  = (HW > TOL_BITS) ? HW : TOL_BITS;
   localparam int MAGCW = (SB > TOL_BITS) ? SB : TOL_BITS;
   localparam int AW    = ANGLE_BITS + 2;

   localparam logic [ANGLE_BITS-1:0] PAN_RESET  = ANGLE_BITS'(PARK_PAN * 256);
   localparam logic [ANGLE_BITS-1:0] TILT_RESET = ANGLE_BITS'(PARK_TILT * 256);

   // Configuration registers.
   logic [TOL_BITS-1:0]   tol_ff;
   logic [GAIN_BITS-1:0]  pan_gain_ff, tilt_gain_ff;
   logic [STEP_BITS-1:0]  max_step_ff;
   logic [LIMIT_BITS-1:0] pan_lower_ff, pan_upper_ff, tilt_lower_ff, tilt_upper_ff;

   // Working registers.
   logic [SB-1:0]         tl_ff, tr_ff, bl_ff, br_ff;
   logic                  neg_ff, neg_in;
   logic [SB-1:0]         mag_ff, mag_in;
   logic [TOL_BITS-1:0]   m_ff, m_in;
   logic [PRODW-1:0]      prod_ff, prod_in;
   logic                  sat_ff, sat_in;
   logic [TOL_BITS-1:0]   rem_ff, rem_in;
   logic [QUO_BITS-1:0]   quo_ff, quo_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [ANGLE_BITS-1:0] pan_angle_ff, pan_angle_in, tilt_angle_ff, tilt_angle_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [POS_BITS-1:0]   pan_pos_ff, pan_pos_in, tilt_pos_ff, tilt_pos_in;

   // Combinational helpers.
   logic [TOL_BITS-1:0]   tol_eff;
   logic [SB-1:0]         src_a0, src_a1, src_b0, src_b1;
   logic [SB:0]           sum_a, sum_b, diff;
   logic [GAIN_BITS-1:0]  gain_sel;
   logic [MULAW-1:0]      mul_a;
   logic [GAIN_BITS-1:0]  mul_b;
   logic [MULPW-1:0]      mul_p;
   logic [MAGCW-1:0]      mag_ext;
   logic [CMPW-1:0]       hi_ext;
   logic [TOL_BITS:0]     trial;
   logic                  trial_ge;
   logic [ANGLE_BITS-1:0] angle_sel;
   logic [LIMIT_BITS-1:0] lower_sel, upper_sel;
   logic [AW-1:0]         angle_sum, lo_ext, hi_lim_ext;
   logic [ANGLE_BITS-1:0] angle_new;
   logic [ANGLE_BITS-1:0] pan_rnd, tilt_rnd;
   logic                  emit_fire;

   // A zero tolerance acts as one.
   assign tol_eff = (tol_ff == '0) ? TOL_BITS'(1) : tol_ff;

   // Pair sums for the selected axis: pan compares left with right, tilt top with bottom.
   always_comb begin
      if (ctrl.axis == AXIS_PAN) begin
         src_a0 = tl_ff; src_a1 = bl_ff; src_b0 = tr_ff; src_b1 = br_ff;
         gain_sel  = pan_gain_ff;
         angle_sel = pan_angle_ff;
         lower_sel = pan_lower_ff;
         upper_sel = pan_upper_ff;
      end else begin
         src_a0 = tl_ff; src_a1 = tr_ff; src_b0 = bl_ff; src_b1 = br_ff;
         gain_sel  = tilt_gain_ff;
         angle_sel = tilt_angle_ff;
         lower_sel = tilt_lower_ff;
         upper_sel = tilt_upper_ff;
      end
   end

   assign sum_a = {1'b0, src_a0} + {1'b0, src_a1};
   assign sum_b = {1'b0, src_b0} + {1'b0, src_b1};
   assign diff  = {1'b0, sum_a[SB:1]} - {1'b0, sum_b[SB:1]};

   // Shared multiplier: magnitude times gain, then that product times the scale.
   assign mul_a   = (ctrl.op == OP_MUL1) ? MULAW'(mag_ff) : prod_ff[MULAW-1:0];
   assign mul_b   = (ctrl.op == OP_MUL1) ? gain_sel : GAIN_BITS'(m_ff);
   assign mul_p   = mul_a * mul_b;
   assign mag_ext = MAGCW'(mag_ff);

   // Divider front end: bits above the kept quotient decide saturation.
   assign hi_ext = CMPW'(prod_ff[PRODW-1:FRAC_BITS+QUO_BITS]);

   // One restoring division step.
   assign trial    = {rem_ff, quo_ff[QUO_BITS-1]};
   assign trial_ge = trial >= {1'b0, tol_eff};

   // Angle update and limiting, compared as signed values.
   assign angle_sum  = neg_ff ? ({2'b00, angle_sel} - {2'b00, step_ff})
                              : ({2'b00, angle_sel} + {2'b00, step_ff});
   assign lo_ext     = {2'b00, lower_sel, {FRAC_BITS{1'b0}}};
   assign hi_lim_ext = {2'b00, upper_sel, {FRAC_BITS{1'b0}}};

   always_comb begin
      if ($signed(angle_sum) < $signed(lo_ext)) begin
         angle_new = lo_ext[ANGLE_BITS-1:0];
      end else if ($signed(angle_sum) > $signed(hi_lim_ext)) begin
         angle_new = hi_lim_ext[ANGLE_BITS-1:0];
      end else begin
         angle_new = angle_sum[ANGLE_BITS-1:0];
      end
   end

   // Result rounding to whole degrees.
   assign pan_rnd   = pan_angle_ff + ANGLE_BITS'(128);
   assign tilt_rnd  = tilt_angle_ff + ANGLE_BITS'(128);
   assign emit_fire = (ctrl.op == OP_EMIT) && !(rsp_valid_ff && !rsp_ready);

   // Operation decode.
   always_comb begin
      neg_in        = neg_ff;
      mag_in        = mag_ff;
      m_in          = m_ff;
      prod_in       = prod_ff;
      sat_in        = sat_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      step_in       = step_ff;
      pan_angle_in  = pan_angle_ff;
      tilt_angle_in = tilt_angle_ff;
      pan_pos_in    = pan_pos_ff;
      tilt_pos_in   = tilt_pos_ff;
      unique case (ctrl.op)
         OP_WAIT: ;
         OP_DIFF: begin
            neg_in = diff[SB];
            mag_in = diff[SB] ? SB'(-diff) : diff[SB-1:0];
         end
         OP_MUL1: begin
            prod_in = PRODW'(mul_p);
            m_in    = (mag_ext <= MAGCW'(tol_eff)) ? mag_ext[TOL_BITS-1:0] : tol_eff;
         end
         OP_MUL2: prod_in = PRODW'(mul_p);
         OP_DIV_INIT: begin
            sat_in = hi_ext >= CMPW'(tol_eff);
            rem_in = hi_ext[TOL_BITS-1:0];
            quo_in = prod_ff[FRAC_BITS+QUO_BITS-1:FRAC_BITS];
         end
         OP_DIV_STEP: begin
            rem_in = trial_ge ? TOL_BITS'(trial - {1'b0, tol_eff}) : trial[TOL_BITS-1:0];
            quo_in = {quo_ff[QUO_BITS-2:0], trial_ge};
         end
         OP_CLAMP: begin
            step_in = (sat_ff || (quo_ff > {1'b0, max_step_ff})) ? max_step_ff
                                                                 : quo_ff[STEP_BITS-1:0];
         end
         OP_UPDATE: begin
            if (ctrl.axis == AXIS_PAN) begin
               pan_angle_in = angle_new;
            end else begin
               tilt_angle_in = angle_new;
            end
         end
         OP_EMIT: begin
            if (emit_fire) begin
               pan_pos_in  = pan_rnd[ANGLE_BITS-1:FRAC_BITS];
               tilt_pos_in = tilt_rnd[ANGLE_BITS-1:FRAC_BITS];
            end
         end
         default: ;
      endcase
   end

   // Result word valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff        <= TOL_RESET;
         pan_gain_ff   <= GAIN_RESET;
         tilt_gain_ff  <= GAIN_RESET;
         max_step_ff   <= MAX_STEP_RESET;
         pan_lower_ff  <= LOWER_RESET;
         pan_upper_ff  <= UPPER_RESET;
         tilt_lower_ff <= LOWER_RESET;
         tilt_upper_ff <= UPPER_RESET;
         pan_angle_ff  <= PAN_RESET;
         tilt_angle_ff <= TILT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pan_angle_ff  <= pan_angle_in;
         tilt_angle_ff <= tilt_angle_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_TOLERANCE:  tol_ff        <= csr_data[TOL_BITS-1:0];
               CSR_PAN_GAIN:   pan_gain_ff   <= csr_data[GAIN_BITS-1:0];
               CSR_TILT_GAIN:  tilt_gain_ff  <= csr_data[GAIN_BITS-1:0];
               CSR_MAX_STEP:   max_step_ff   <= csr_data[STEP_BITS-1:0];
               CSR_PAN_LOWER:  pan_lower_ff  <= csr_data[LIMIT_BITS-1:0];
               CSR_PAN_UPPER:  pan_upper_ff  <= csr_data[LIMIT_BITS-1:0];
               CSR_TILT_LOWER: tilt_lower_ff <= csr_data[LIMIT_BITS-1:0];
               CSR_TILT_UPPER: tilt_upper_ff <= csr_data[LIMIT_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         tl_ff <= light_top_left;
         tr_ff <= light_top_right;
         bl_ff <= light_bottom_left;
         br_ff <= light_bottom_right;
      end
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      m_ff        <= m_in;
      prod_ff     <= prod_in;
      sat_ff      <= sat_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      step_ff     <= step_in;
      pan_pos_ff  <= pan_pos_in;
      tilt_pos_ff <= tilt_pos_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign pan_position  = pan_pos_ff;
   assign tilt_position = tilt_pos_ff;

   // The clamped step never exceeds the step limit.
   assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_CLAMP) |=> step_ff <= $past(max_step_ff))
      else $error("step exceeds limit");

   // Stored angles stay within the range an 8-bit degree limit allows.
   assert property (@(posedge clock) disable iff (reset)
      (pan_angle_ff <= 16'hFF00) && (tilt_angle_ff <= 16'hFF00))
      else $error("angle out of range");

endmodule

`default_nettype wire
